// ===== rtl/core/cwa_pkg.sv =====
// Shared widths and constants for the centered window average block.
package cwa_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int K_W        = 6;
  localparam int SPAN_W     = K_W + 1;
  localparam int SUM_W      = 23;
  localparam int HIST_DEPTH = 128;
  localparam int ADDR_W     = $clog2(HIST_DEPTH);
  localparam int QCNT_W     = $clog2(SUM_W);

  localparam logic [K_W-1:0] RADIUS_MAX   = K_W'(63);
  localparam logic [K_W-1:0] RADIUS_RESET = K_W'(1);

endpackage

// ===== rtl/core/cwa_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module cwa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write one entry, read one entry every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/cwa_div.sv =====
// Restoring divider: one quotient bit per cycle, window sum by window span.
module cwa_div import cwa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [SUM_W-1:0]    dividend,
  input  logic [SPAN_W-1:0]   divisor,
  output logic                done,
  output logic [SAMPLE_W-1:0] quotient
);

  logic              busy;
  logic [QCNT_W-1:0] cnt;
  logic [SPAN_W-1:0] rem;
  logic [SUM_W-1:0]  dq;
  logic [SPAN_W-1:0] dvs;

  logic [SPAN_W:0]   trial;
  logic              ge;
  logic [SPAN_W:0]   diff;

  // shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem, dq[SUM_W-1]};
    ge    = trial >= {1'b0, dvs};
    diff  = trial - {1'b0, dvs};
  end

  // control: stay busy until every dividend bit has been shifted through
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == QCNT_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // datapath: partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq  <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
      dq  <= {dq[SUM_W-2:0], ge};
    end
  end

  assign quotient = dq[SAMPLE_W-1:0];

endmodule

// ===== rtl/core/centered_window_average.sv =====
// Centered moving average of radius k over a sample stream.
// Input word: sample and last_sample, taken on in_valid with in_stall low.
// Output word: average, has_average, last_result, offered on out_valid and
// taken when out_stall is low. The result for position i leaves when
// sample i+k has been taken; positions whose 2k+1 window does not fit at
// either end of the stream carry has_average low and average zero.
// radius_we writes radius_data as the half width k and starts a new stream.
// One word at a time: in_stall is high from the accept until its last
// result is loaded into the output register. A word with a full window
// passes through the accept, the sum update, the restoring divider up to
// its done flag and the load into the output register; a word with no
// full window skips the divider. The last word of a stream then flushes
// its remaining positions one at a time, up to k.
// A stalled receiver holds the output register and the sequencer waits.
// Reset (rst, synchronous) clears the sum, fill count, write pointer and
// output valid and sets radius to 1. History needs no clearing: only
// entries written in the current stream are read.
module centered_window_average import cwa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                radius_we,
  input  logic [K_W-1:0]      radius_data,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                last_sample,
  input  logic                in_valid,
  output logic                in_stall,
  output logic [SAMPLE_W-1:0] average,
  output logic                has_average,
  output logic                last_result,
  output logic                out_valid,
  input  logic                out_stall
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ACCUM = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0]          state;
  logic [K_W-1:0]      radius;
  logic [ADDR_W-1:0]   write_pointer;
  logic [SPAN_W-1:0]   fill_count;
  logic [SUM_W-1:0]    window_sum;
  logic [SAMPLE_W-1:0] sample_hold;
  logic                last_hold;
  logic                old_valid;
  logic                full;
  logic [K_W-1:0]      flush_cnt;

  logic                accept;
  logic                out_free;
  logic [SPAN_W-1:0]   span;
  logic [ADDR_W-1:0]   raddr;
  logic [SAMPLE_W-1:0] rdata;
  logic [SUM_W-1:0]    sum_next;
  logic [SPAN_W-1:0]   fill_next;
  logic                due;
  logic                full_next;
  logic [K_W-1:0]      flush_next;
  logic                div_start;
  logic                div_done;
  logic [SAMPLE_W-1:0] quotient;

  assign span     = {radius, 1'b1};
  assign accept   = in_valid && (state == S_IDLE);
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign raddr    = write_pointer - ADDR_W'(span);

  // sum and fill count after the held sample enters the window
  always_comb begin
    sum_next   = window_sum + SUM_W'(sample_hold)
                 - (old_valid ? SUM_W'(rdata) : SUM_W'(0));
    fill_next  = (fill_count < span) ? fill_count + 1'b1 : fill_count;
    due        = fill_next >= (SPAN_W'(radius) + 1'b1);
    full_next  = fill_next == span;
    flush_next = (fill_next < SPAN_W'(radius)) ? fill_next[K_W-1:0] : radius;
  end

  assign div_start = (state == S_ACCUM) && due && full_next;

  cwa_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(HIST_DEPTH)
  ) u_history (
    .clk  (clk),
    .we   (accept),
    .waddr(write_pointer),
    .wdata(sample),
    .raddr(raddr),
    .rdata(rdata)
  );

  cwa_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(sum_next),
    .divisor (span),
    .done    (div_done),
    .quotient(quotient)
  );

  // capture the accepted word
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_hold <= sample;
      last_hold   <= last_sample;
      old_valid   <= fill_count >= span;
    end
    if (state == S_ACCUM) begin
      full <= full_next;
    end
  end

  // sequencer and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      radius        <= RADIUS_RESET;
      write_pointer <= '0;
      fill_count    <= '0;
      window_sum    <= '0;
      flush_cnt     <= '0;
    end else begin
      if (radius_we) begin
        radius     <= (radius_data > RADIUS_MAX) ? RADIUS_MAX : radius_data;
        fill_count <= '0;
        window_sum <= '0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            write_pointer <= write_pointer + 1'b1;
            state         <= S_ACCUM;
          end
        end
        S_ACCUM: begin
          window_sum <= last_hold ? '0 : sum_next;
          fill_count <= last_hold ? '0 : fill_next;
          flush_cnt  <= last_hold ? flush_next : '0;
          if (due && full_next) begin
            state <= S_DIV;
          end else if (due) begin
            state <= S_EMIT;
          end else if (last_hold && (flush_next != '0)) begin
            state <= S_FLUSH;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= (flush_cnt != '0) ? S_FLUSH : S_IDLE;
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            flush_cnt <= flush_cnt - 1'b1;
            if (flush_cnt == K_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register: load a result or drop the taken one
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_EMIT || state == S_FLUSH) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      average     <= full ? quotient : '0;
      has_average <= full;
      last_result <= last_hold && (flush_cnt == '0);
    end else if (state == S_FLUSH && out_free) begin
      average     <= '0;
      has_average <= 1'b0;
      last_result <= flush_cnt == K_W'(1);
    end
  end

endmodule

// ===== rtl/core/cwa_checker.sv =====
// Port-level checks for the centered window average block, bound to the top level.
module cwa_checker import cwa_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic [SAMPLE_W-1:0] average,
  input logic                has_average,
  input logic                last_result,
  input logic                out_valid,
  input logic                out_stall
);

  // hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(average)
      && $stable(has_average) && $stable(last_result))
    else $error("stalled output word changed");

  // a word without an average carries zero
  a_no_avg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_average |-> average == '0)
    else $error("average nonzero without a full window");

  // the block is busy after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an accept");

  // reset empties the output register and opens the input
  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("output valid or input stall after reset");

endmodule

bind centered_window_average cwa_checker u_cwa_checker (.*);
